// File: rtl/opnf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opnf_pkg
// Shared constants and controller/datapath types for the origin plane fit.
// ----------------------------------------------------------------------------
package opnf_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 16;
  localparam int NORM_W     = 16;
  localparam int DIST_W     = 15;
  localparam int STEP_W     = 6;
  localparam int ROW_W      = 3 * COORD_W;

  localparam logic [DIST_W-1:0] DIST_RESET = 15'd205;
  localparam logic [14:0]       NORM_ONE   = 15'd16384;

  // root digit loop runs one result bit per step, quotient one bit per step
  localparam logic [STEP_W-1:0] SQRT_LAST = 6'd31;
  localparam logic [STEP_W-1:0] DIV_LAST  = 6'd14;
  localparam logic [STEP_W-1:0] TRIPLE_LAST = 6'd2;
  localparam logic [STEP_W-1:0] DRAIN_LAST  = 6'd1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FIT_INIT,
    ST_RD_A,
    ST_RD_B,
    ST_LD_B,
    ST_CROSS,
    ST_CHECK,
    ST_SQ,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_NORM,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_NEXT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic              load_a;
    logic              load_b;
    logic              cross_en;
    logic [1:0]        sel;
    logic              clr_acc;
    logic              sq_en;
    logic              sqrt_init;
    logic              sqrt_step;
    logic              div_init;
    logic              div_step;
    logic              norm;
    logic              scan_rd;
    logic              best_clear;
    logic              best_update;
  } cmd_t;

  typedef struct packed {
    logic c_zero;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/opnf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opnf_datapath
// Point store, cross product, root and divide units, inlier scan, best plane.
// ----------------------------------------------------------------------------
module opnf_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire opnf_pkg::cmd_t                     cmd_i,
  output opnf_pkg::status_t                       status_o,
  input  wire logic signed [opnf_pkg::COORD_W-1:0] point_x_i,
  input  wire logic signed [opnf_pkg::COORD_W-1:0] point_y_i,
  input  wire logic signed [opnf_pkg::COORD_W-1:0] point_z_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [opnf_pkg::DIST_W-1:0]        cfg_data_i,
  output logic signed [opnf_pkg::NORM_W-1:0]      normal_x_o,
  output logic signed [opnf_pkg::NORM_W-1:0]      normal_y_o,
  output logic signed [opnf_pkg::NORM_W-1:0]      normal_z_o,
  output logic [opnf_pkg::CNT_W-1:0]              inlier_count_o,
  output logic                                    found_o
);

  localparam int CW = opnf_pkg::COORD_W;

  logic [opnf_pkg::ROW_W-1:0] mem_q [opnf_pkg::MAX_POINTS];
  logic [opnf_pkg::ROW_W-1:0] rd_q;

  logic signed [CW-1:0] a_q [3];
  logic signed [CW-1:0] b_q [3];
  logic signed [CW-1:0] rd_c [3];
  logic signed [32:0]   c_q [3];
  logic [30:0]          m [3];

  logic [63:0] acc_q, rem_q, root_q, bit_q;
  logic [45:0] drem_q [3];
  logic [45:0] dsr_q;
  logic [14:0] quo_q [3];
  logic signed [opnf_pkg::NORM_W-1:0] n_q [3];
  logic signed [31:0] p_q [3];

  logic                        v1_q, v2_q;
  logic [opnf_pkg::CNT_W-1:0]  hits_q;
  logic [opnf_pkg::DIST_W-1:0] dist_q;
  logic                        best_valid_q;
  logic [opnf_pkg::CNT_W-1:0]  best_count_q;
  logic signed [opnf_pkg::NORM_W-1:0] best_n_q [3];

  // operand muxes
  logic signed [CW-1:0] m0a, m0b, m1a, m1b;
  logic signed [32:0]   cross_v;
  logic [30:0]          sq_m;
  logic [63:0]          sq_t;
  logic [63:0]          sqrt_t;
  logic [31:0]          r;
  logic signed [33:0]   dsum;
  logic [33:0]          dmag;
  logic [33:0]          bound;

  assign rd_c[0] = rd_q[3*CW-1:2*CW];
  assign rd_c[1] = rd_q[2*CW-1:CW];
  assign rd_c[2] = rd_q[CW-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m[k] = c_q[k][32] ? 31'(-c_q[k]) : c_q[k][30:0];
    end
  end

  always_comb begin
    case (cmd_i.sel)
      2'd0: begin
        m0a = a_q[1]; m0b = b_q[2]; m1a = a_q[2]; m1b = b_q[1];
      end
      2'd1: begin
        m0a = a_q[2]; m0b = b_q[0]; m1a = a_q[0]; m1b = b_q[2];
      end
      default: begin
        m0a = a_q[0]; m0b = b_q[1]; m1a = a_q[1]; m1b = b_q[0];
      end
    endcase
    cross_v = 33'(m0a * m0b) - 33'(m1a * m1b);
    case (cmd_i.sel)
      2'd0:    sq_m = m[0];
      2'd1:    sq_m = m[1];
      default: sq_m = m[2];
    endcase
    sq_t   = 64'(sq_m) * 64'(sq_m);
    sqrt_t = root_q + bit_q;
    r      = root_q[31:0];
    dsum   = 34'(p_q[0]) + 34'(p_q[1]) + 34'(p_q[2]);
    dmag   = dsum[33] ? 34'(-dsum) : 34'(dsum);
    bound  = {5'd0, dist_q, 14'd0};
  end

  assign status_o.c_zero = (c_q[0] == '0) && (c_q[1] == '0) && (c_q[2] == '0);

  // point store
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.addr] <= {point_x_i, point_y_i, point_z_i};
    end
    rd_q <= mem_q[cmd_i.addr];
  end

  // arithmetic payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a) begin
      for (int k = 0; k < 3; k++) a_q[k] <= rd_c[k];
    end
    if (cmd_i.load_b) begin
      for (int k = 0; k < 3; k++) b_q[k] <= rd_c[k];
    end
    if (cmd_i.cross_en) begin
      c_q[cmd_i.sel] <= cross_v;
    end
    if (cmd_i.clr_acc) begin
      acc_q <= '0;
    end else if (cmd_i.sq_en) begin
      acc_q <= acc_q + sq_t;
    end
    if (cmd_i.sqrt_init) begin
      rem_q  <= acc_q;
      root_q <= '0;
      bit_q  <= 64'd1 << 62;
    end else if (cmd_i.sqrt_step) begin
      if (rem_q >= sqrt_t) begin
        rem_q  <= rem_q - sqrt_t;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.div_init) begin
      for (int k = 0; k < 3; k++) begin
        drem_q[k] <= {1'b0, m[k], 14'd0} + 46'(r[31:1]);
        quo_q[k]  <= '0;
      end
      dsr_q <= {r, 14'd0};
    end else if (cmd_i.div_step) begin
      for (int k = 0; k < 3; k++) begin
        if (drem_q[k] >= dsr_q) begin
          drem_q[k] <= drem_q[k] - dsr_q;
          quo_q[k]  <= {quo_q[k][13:0], 1'b1};
        end else begin
          quo_q[k]  <= {quo_q[k][13:0], 1'b0};
        end
      end
      dsr_q <= dsr_q >> 1;
    end
    if (cmd_i.norm) begin
      for (int k = 0; k < 3; k++) begin
        logic [14:0] u;
        u = (quo_q[k] > opnf_pkg::NORM_ONE) ? opnf_pkg::NORM_ONE : quo_q[k];
        n_q[k] <= c_q[k][32] ? -$signed({1'b0, u}) : $signed({1'b0, u});
      end
    end
    if (v1_q) begin
      for (int k = 0; k < 3; k++) p_q[k] <= n_q[k] * rd_c[k];
    end
    if (cmd_i.best_clear) begin
      for (int k = 0; k < 3; k++) best_n_q[k] <= '0;
    end else if (cmd_i.best_update && (!best_valid_q || hits_q > best_count_q)) begin
      for (int k = 0; k < 3; k++) best_n_q[k] <= n_q[k];
    end
  end

  // control state: scan pipe, counters, threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      hits_q       <= '0;
      dist_q       <= opnf_pkg::DIST_RESET;
      best_valid_q <= 1'b0;
      best_count_q <= '0;
    end else begin
      v1_q <= cmd_i.scan_rd;
      v2_q <= v1_q;
      if (cfg_we_i) begin
        dist_q <= cfg_data_i;
      end
      if (cmd_i.norm) begin
        hits_q <= '0;
      end else if (v2_q && (dmag < bound)) begin
        hits_q <= hits_q + 1'b1;
      end
      if (cmd_i.best_clear) begin
        best_valid_q <= 1'b0;
        best_count_q <= '0;
      end else if (cmd_i.best_update && (!best_valid_q || hits_q > best_count_q)) begin
        best_valid_q <= 1'b1;
        best_count_q <= hits_q;
      end
    end
  end

  assign normal_x_o     = best_n_q[0];
  assign normal_y_o     = best_n_q[1];
  assign normal_z_o     = best_n_q[2];
  assign inlier_count_o = best_count_q;
  assign found_o        = best_valid_q;

endmodule

`default_nettype wire

// File: rtl/opnf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opnf_ctrl
// Sequencer: point loading, pair loop, per-pair steps, scan and result.
// ----------------------------------------------------------------------------
module opnf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic              last_point_i,
  input  wire opnf_pkg::status_t status_i,
  output opnf_pkg::cmd_t         cmd_o,
  output logic                   busy,
  output logic                   done_o,
  output logic                   overflowed_o
);

  opnf_pkg::state_e state_q, state_d;
  logic [opnf_pkg::CNT_W-1:0]  count_q, count_d;
  logic [opnf_pkg::ADDR_W-1:0] i_q, i_d, j_q, j_d;
  logic [opnf_pkg::STEP_W-1:0] step_q, step_d;
  logic                        drop_q, drop_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= opnf_pkg::ST_IDLE;
      count_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
      step_q  <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      i_q     <= i_d;
      j_q     <= j_d;
      step_q  <= step_d;
      drop_q  <= drop_d;
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    i_d     = i_q;
    j_d     = j_q;
    step_d  = step_q;
    drop_d  = drop_q;
    cmd_o   = '0;
    cmd_o.sel = step_q[1:0];

    unique case (state_q)
      opnf_pkg::ST_IDLE: begin
        cmd_o.addr = count_q[opnf_pkg::ADDR_W-1:0];
        if (start) begin
          if (count_q < opnf_pkg::CNT_W'(opnf_pkg::MAX_POINTS)) begin
            cmd_o.wr_en = 1'b1;
            count_d     = count_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          if (last_point_i) state_d = opnf_pkg::ST_FIT_INIT;
        end
      end
      opnf_pkg::ST_FIT_INIT: begin
        cmd_o.best_clear = 1'b1;
        i_d = '0;
        j_d = opnf_pkg::ADDR_W'(1);
        state_d = (count_q < opnf_pkg::CNT_W'(2)) ? opnf_pkg::ST_DONE : opnf_pkg::ST_RD_A;
      end
      opnf_pkg::ST_RD_A: begin
        cmd_o.addr = i_q;
        state_d    = opnf_pkg::ST_RD_B;
      end
      opnf_pkg::ST_RD_B: begin
        cmd_o.addr   = j_q;
        cmd_o.load_a = 1'b1;
        state_d      = opnf_pkg::ST_LD_B;
      end
      opnf_pkg::ST_LD_B: begin
        cmd_o.load_b = 1'b1;
        step_d       = '0;
        state_d      = opnf_pkg::ST_CROSS;
      end
      opnf_pkg::ST_CROSS: begin
        cmd_o.cross_en = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == opnf_pkg::TRIPLE_LAST) state_d = opnf_pkg::ST_CHECK;
      end
      opnf_pkg::ST_CHECK: begin
        cmd_o.clr_acc = 1'b1;
        step_d = '0;
        state_d = status_i.c_zero ? opnf_pkg::ST_NEXT : opnf_pkg::ST_SQ;
      end
      opnf_pkg::ST_SQ: begin
        cmd_o.sq_en = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == opnf_pkg::TRIPLE_LAST) state_d = opnf_pkg::ST_SQRT_INIT;
      end
      opnf_pkg::ST_SQRT_INIT: begin
        cmd_o.sqrt_init = 1'b1;
        step_d  = '0;
        state_d = opnf_pkg::ST_SQRT;
      end
      opnf_pkg::ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == opnf_pkg::SQRT_LAST) state_d = opnf_pkg::ST_DIV_INIT;
      end
      opnf_pkg::ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        step_d  = '0;
        state_d = opnf_pkg::ST_DIV;
      end
      opnf_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == opnf_pkg::DIV_LAST) state_d = opnf_pkg::ST_NORM;
      end
      opnf_pkg::ST_NORM: begin
        cmd_o.norm = 1'b1;
        step_d  = '0;
        state_d = opnf_pkg::ST_SCAN;
      end
      opnf_pkg::ST_SCAN: begin
        cmd_o.addr    = step_q[opnf_pkg::ADDR_W-1:0];
        cmd_o.scan_rd = 1'b1;
        step_d = step_q + 1'b1;
        if (opnf_pkg::CNT_W'(step_q) == count_q - 1'b1) begin
          step_d  = '0;
          state_d = opnf_pkg::ST_DRAIN;
        end
      end
      opnf_pkg::ST_DRAIN: begin
        step_d = step_q + 1'b1;
        if (step_q == opnf_pkg::DRAIN_LAST) state_d = opnf_pkg::ST_UPDATE;
      end
      opnf_pkg::ST_UPDATE: begin
        cmd_o.best_update = 1'b1;
        state_d = opnf_pkg::ST_NEXT;
      end
      opnf_pkg::ST_NEXT: begin
        if (opnf_pkg::CNT_W'(j_q) + 1'b1 < count_q) begin
          j_d     = j_q + 1'b1;
          state_d = opnf_pkg::ST_RD_A;
        end else if (opnf_pkg::CNT_W'(i_q) + opnf_pkg::CNT_W'(2) < count_q) begin
          i_d     = i_q + 1'b1;
          j_d     = i_q + opnf_pkg::ADDR_W'(2);
          state_d = opnf_pkg::ST_RD_A;
        end else begin
          state_d = opnf_pkg::ST_DONE;
        end
      end
      opnf_pkg::ST_DONE: begin
        count_d = '0;
        drop_d  = 1'b0;
        state_d = opnf_pkg::ST_IDLE;
      end
      default: state_d = opnf_pkg::ST_IDLE;
    endcase
  end

  assign busy         = (state_q != opnf_pkg::ST_IDLE);
  assign done_o       = (state_q == opnf_pkg::ST_DONE);
  assign overflowed_o = drop_q;

endmodule

`default_nettype wire

// File: rtl/origin_plane_normal_fit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// origin_plane_normal_fit
// Exhaustive pair search for the best plane through the origin over a point set.
// ----------------------------------------------------------------------------
// Points (Q3.12) are written one word per start pulse while busy is low. The
// word flagged last_point starts the fit and busy stays high until the result.
// For N stored points the fit visits all N(N-1)/2 pairs: each goes through the
// shared units (3 cross steps, 3 square steps, 32 root steps, 15 divide steps,
// glue) and then scans the point store through its single read port. A pair
// with a zero cross product is skipped. The result is on the output ports when
// done_o is high for exactly one cycle and holds until the next fit clears it;
// there is no back-pressure, so the receiver must capture it then. Points past
// 64 are dropped and reported through overflowed_o. The threshold register is
// to be written through cfg_we_i/cfg_data_i only while idle, which the block
// does not enforce; its reset value is 205.
// ----------------------------------------------------------------------------
module origin_plane_normal_fit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [opnf_pkg::COORD_W-1:0] point_x_i,
  input  wire logic signed [opnf_pkg::COORD_W-1:0] point_y_i,
  input  wire logic signed [opnf_pkg::COORD_W-1:0] point_z_i,
  input  wire logic                                last_point_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [opnf_pkg::DIST_W-1:0]         cfg_data_i,
  output logic                                     done_o,
  output logic signed [opnf_pkg::NORM_W-1:0]       normal_x_o,
  output logic signed [opnf_pkg::NORM_W-1:0]       normal_y_o,
  output logic signed [opnf_pkg::NORM_W-1:0]       normal_z_o,
  output logic [opnf_pkg::CNT_W-1:0]               inlier_count_o,
  output logic                                     found_o,
  output logic                                     overflowed_o
);

  // controller drives the datapath one command word per cycle
  opnf_pkg::cmd_t    cmd;
  opnf_pkg::status_t status;

  opnf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .last_point_i (last_point_i),
    .status_i     (status),
    .cmd_o        (cmd),
    .busy         (busy),
    .done_o       (done_o),
    .overflowed_o (overflowed_o)
  );

  // best plane registers hold until the next fit clears them
  opnf_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .point_z_i      (point_z_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .normal_x_o     (normal_x_o),
    .normal_y_o     (normal_y_o),
    .normal_z_o     (normal_z_o),
    .inlier_count_o (inlier_count_o),
    .found_o        (found_o)
  );

endmodule

`default_nettype wire
